@@ hw/rtl/cht_pkg.sv @@
// cht_pkg: table size, opcodes, status codes, register indexes, slot entry type
// and the address mixing helpers of the connection hash table
// no dependencies
package cht_pkg;

   localparam int TABLE_SIZE = 2048;

   localparam logic [2:0] OP_LOOKUP   = 3'd0;
   localparam logic [2:0] OP_INSERT   = 3'd1;
   localparam logic [2:0] OP_REMOVE   = 3'd2;
   localparam logic [2:0] OP_READ     = 3'd3;
   localparam logic [2:0] OP_SHUTDOWN = 3'd4;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_DUP  = 2'd1;
   localparam logic [1:0] STATUS_SHUT = 2'd2;
   localparam logic [1:0] STATUS_FULL = 2'd3;

   localparam logic [2:0] CSR_ADDRESS_SALT     = 3'd0;
   localparam logic [2:0] CSR_PORT_SEED        = 3'd1;
   localparam logic [2:0] CSR_FLOOD_SALT       = 3'd2;
   localparam logic [2:0] CSR_FLOOD_LIMIT      = 3'd3;
   localparam logic [2:0] CSR_PROBE_MULTIPLIER = 3'd4;
   localparam logic [2:0] CSR_PROBE_INCREMENT  = 3'd5;
   localparam logic [2:0] CSR_BACK_MULTIPLIER  = 3'd6;
   localparam logic [2:0] CSR_BACK_INCREMENT   = 3'd7;

   localparam logic [31:0] MIX_XOR   = 32'd61;
   localparam logic [31:0] MIX_MUL   = 32'h27d4eb2d;
   localparam logic [11:0] FLOOD_MAX = 12'd4095;

   typedef struct packed {
      logic        valid;
      logic        coll;
      logic [47:0] key;
   } slot_entry_type;

   // first half of the address mix, up to the multiply
   function automatic logic [31:0] mix_pre(input logic [31:0] v, input logic [31:0] salt);
      logic [31:0] a;
      logic [31:0] b;
      a = (v ^ MIX_XOR) ^ (v >> 16);
      b = a + (a << 3);
      return b ^ (b >> 4) ^ salt;
   endfunction

   // second half of the address mix, after the multiply
   function automatic logic [31:0] mix_post(input logic [31:0] v);
      return v ^ (v >> 15);
   endfunction

endpackage

@@ hw/rtl/connection_hash_table_flood_guard.sv @@
// connection_hash_table_flood_guard: open addressing connection table with
// per address flood counters; uses cht_pkg and two cht_ram instances
//
// channel  direction  handshake          payload
// req      in         req_valid/stall    opcode ip_address port_number slot_index flood_index
// rsp      out        rsp_valid/stall    status found slot_out flood_out flooded stored_ip
//                                        stored_port population
// csr      in         csr_write          csr_index csr_data
//
// sequencer around one shared 32x32 multiplier; steps from accept to next accept:
// lookup/insert: four hash steps, then ram address and read per probed slot with a multiply step
//   between slots, then output and idle; remove: ram address and read, the same per backward step,
//   output, idle; read: ram address, read, output, idle; shutdown and unknown opcodes: output, idle
// after reset a clearing pass over every slot and flood counter holds req_stall high
// a finished item waits while the output register is held by rsp_stall
module connection_hash_table_flood_guard
   import cht_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [31:0] req_ip_address,
   input  logic [15:0] req_port_number,
   input  logic [10:0] req_slot_index,
   input  logic [10:0] req_flood_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_found,
   output logic [10:0] rsp_slot_out,
   output logic [10:0] rsp_flood_out,
   output logic        rsp_flooded,
   output logic [31:0] rsp_stored_ip,
   output logic [15:0] rsp_stored_port,
   output logic [11:0] rsp_population,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int AW = $clog2(TABLE_SIZE);

   localparam logic [3:0] S_CLR   = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_MIXA  = 4'd2;
   localparam logic [3:0] S_MIXF  = 4'd3;
   localparam logic [3:0] S_PORT  = 4'd4;
   localparam logic [3:0] S_HOME  = 4'd5;
   localparam logic [3:0] S_PROBE = 4'd6;
   localparam logic [3:0] S_CHECK = 4'd7;
   localparam logic [3:0] S_NEXT  = 4'd8;
   localparam logic [3:0] S_OUT   = 4'd9;

   // configuration registers
   logic [31:0] addr_salt_ff, port_seed_ff, flood_salt_ff;
   logic [11:0] flood_limit_ff;
   logic [31:0] probe_mul_ff, probe_inc_ff, back_mul_ff, back_inc_ff;

   // sequencer state
   logic [3:0]    state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [2:0]    op_ff, op_in;
   logic [31:0]   ip_ff, ip_in;
   logic [15:0]   port_ff, port_in;
   logic          walk_ff, walk_in;
   logic [AW-1:0] k_ff, k_in;
   logic [AW-1:0] f_ff, f_in;
   logic [AW-1:0] n_ff, n_in;
   logic [31:0]   h_ff, h_in;
   logic [31:0]   mul_ff, mul_in;
   logic [AW:0]   occ_ff, occ_in;
   logic          closed_ff, closed_in;

   // working result
   logic [1:0]    res_status_ff, res_status_in;
   logic          res_found_ff, res_found_in;
   logic [AW-1:0] res_slot_ff, res_slot_in;
   logic [AW-1:0] res_flood_ff, res_flood_in;
   logic          res_flooded_ff, res_flooded_in;
   logic [47:0]   res_key_ff, res_key_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic        rsp_found_ff, rsp_found_in;
   logic [10:0] rsp_slot_ff, rsp_slot_in;
   logic [10:0] rsp_flood_ff, rsp_flood_in;
   logic        rsp_flooded_ff, rsp_flooded_in;
   logic [47:0] rsp_key_ff, rsp_key_in;
   logic [11:0] rsp_pop_ff, rsp_pop_in;

   // shared multiplier operands
   logic [31:0] mul_a, mul_b;

   // memories
   logic           slot_we;
   logic [AW-1:0]  slot_waddr;
   slot_entry_type slot_wdata, slot_q;
   logic           flood_we;
   logic [AW-1:0]  flood_waddr;
   logic [11:0]    flood_wdata, flood_q;

   logic        accept, in_range, last, out_free, ent_v, ent_c, key_hit;
   logic [47:0] want;

   assign accept   = req_valid && !req_stall;
   assign in_range = (32'(req_slot_index) < 32'(TABLE_SIZE));
   assign last     = &n_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign want     = {ip_ff, port_ff};
   // a shut down table reads as empty and unmarked
   assign ent_v    = slot_q.valid && !closed_ff;
   assign ent_c    = slot_q.coll && !closed_ff;
   assign key_hit  = (slot_q.key == want);
   assign req_stall = (state_ff != S_IDLE);

   cht_ram #(.WIDTH($bits(slot_entry_type)), .DEPTH(TABLE_SIZE)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_addr (k_ff),
      .rd_data (slot_q)
   );

   cht_ram #(.WIDTH(12), .DEPTH(TABLE_SIZE)) u_flood_ram (
      .clock   (clock),
      .wr_en   (flood_we),
      .wr_addr (flood_waddr),
      .wr_data (flood_wdata),
      .rd_addr (f_ff),
      .rd_data (flood_q)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_salt_ff   <= '0;
         port_seed_ff   <= '0;
         flood_salt_ff  <= '0;
         flood_limit_ff <= 12'd16;
         probe_mul_ff   <= 32'd1;
         probe_inc_ff   <= 32'd1;
         back_mul_ff    <= 32'd1;
         back_inc_ff    <= 32'hffffffff;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_ADDRESS_SALT:     addr_salt_ff   <= csr_data;
            CSR_PORT_SEED:        port_seed_ff   <= csr_data;
            CSR_FLOOD_SALT:       flood_salt_ff  <= csr_data;
            CSR_FLOOD_LIMIT:      flood_limit_ff <= csr_data[11:0];
            CSR_PROBE_MULTIPLIER: probe_mul_ff   <= csr_data;
            CSR_PROBE_INCREMENT:  probe_inc_ff   <= csr_data;
            CSR_BACK_MULTIPLIER:  back_mul_ff    <= csr_data;
            CSR_BACK_INCREMENT:   back_inc_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // shared multiplier: low 32 bits of the product, registered
   always_comb begin
      mul_a = 32'(k_ff);
      mul_b = probe_mul_ff;
      unique case (state_ff)
         S_MIXA: begin
            mul_a = mix_pre(ip_ff, addr_salt_ff);
            mul_b = MIX_MUL;
         end
         S_MIXF: begin
            mul_a = mix_pre(ip_ff, flood_salt_ff);
            mul_b = MIX_MUL;
         end
         S_PORT: begin
            mul_a = {16'd0, port_ff};
            mul_b = {port_seed_ff[29:0], 2'b01};
         end
         S_CHECK: begin
            // backward step only needs the low bits of k + back_increment
            if (op_ff == OP_REMOVE) begin
               mul_a = 32'(k_ff) + back_inc_ff;
               mul_b = back_mul_ff;
            end
         end
         default: ;
      endcase
      mul_in = mul_a * mul_b;
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      op_in          = op_ff;
      ip_in          = ip_ff;
      port_in        = port_ff;
      walk_in        = walk_ff;
      k_in           = k_ff;
      f_in           = f_ff;
      n_in           = n_ff;
      h_in           = h_ff;
      occ_in         = occ_ff;
      closed_in      = closed_ff;
      res_status_in  = res_status_ff;
      res_found_in   = res_found_ff;
      res_slot_in    = res_slot_ff;
      res_flood_in   = res_flood_ff;
      res_flooded_in = res_flooded_ff;
      res_key_in     = res_key_ff;
      slot_we        = 1'b0;
      slot_waddr     = k_ff;
      slot_wdata     = slot_q;
      flood_we       = 1'b0;
      flood_waddr    = f_ff;
      flood_wdata    = flood_q;

      unique case (state_ff)
         S_CLR: begin
            // sweep every slot and flood counter to zero after reset
            slot_we     = 1'b1;
            slot_waddr  = clr_ff;
            slot_wdata  = '0;
            flood_we    = 1'b1;
            flood_waddr = clr_ff;
            flood_wdata = '0;
            clr_in      = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               op_in          = req_opcode;
               ip_in          = req_ip_address;
               port_in        = req_port_number;
               k_in           = AW'(req_slot_index);
               f_in           = AW'(req_flood_index);
               n_in           = '0;
               walk_in        = 1'b0;
               res_status_in  = STATUS_OK;
               res_found_in   = 1'b0;
               res_slot_in    = '0;
               res_flood_in   = '0;
               res_flooded_in = 1'b0;
               res_key_in     = '0;
               state_in       = S_OUT;
               unique case (req_opcode)
                  OP_LOOKUP, OP_INSERT: begin
                     if (closed_ff) begin
                        res_status_in = STATUS_SHUT;
                     end else begin
                        state_in = S_MIXA;
                     end
                  end
                  OP_REMOVE: begin
                     if (in_range) begin
                        state_in = S_PROBE;
                     end
                  end
                  OP_READ: begin
                     if (closed_ff) begin
                        res_status_in = STATUS_SHUT;
                     end else if (in_range) begin
                        state_in = S_PROBE;
                     end
                  end
                  OP_SHUTDOWN: begin
                     closed_in = 1'b1;
                     occ_in    = '0;
                  end
                  default: ;
               endcase
            end
         end
         S_MIXA: begin
            state_in = S_MIXF;
         end
         S_MIXF: begin
            h_in     = mix_post(mul_ff);
            state_in = S_PORT;
         end
         S_PORT: begin
            f_in     = AW'(mix_post(mul_ff));
            state_in = S_HOME;
         end
         S_HOME: begin
            k_in     = AW'(h_ff + mul_ff);
            state_in = S_PROBE;
         end
         S_PROBE: begin
            state_in = S_CHECK;
         end
         S_NEXT: begin
            k_in     = walk_ff ? AW'(mul_ff) : AW'(mul_ff + probe_inc_ff);
            state_in = S_PROBE;
         end
         S_CHECK: begin
            state_in = S_OUT;
            unique case (op_ff)
               OP_LOOKUP: begin
                  if (ent_v && key_hit) begin
                     res_found_in = 1'b1;
                     res_slot_in  = k_ff;
                  end else if (!ent_c || last) begin
                     res_flooded_in = (flood_q >= flood_limit_ff);
                  end else begin
                     n_in     = n_ff + 1'b1;
                     state_in = S_NEXT;
                  end
               end
               OP_INSERT: begin
                  if (!ent_v) begin
                     slot_we     = 1'b1;
                     slot_wdata  = '{valid: 1'b1, coll: ent_c, key: want};
                     occ_in      = occ_ff + 1'b1;
                     res_slot_in  = k_ff;
                     res_flood_in = f_ff;
                     if (flood_q < FLOOD_MAX) begin
                        flood_we    = 1'b1;
                        flood_wdata = flood_q + 12'd1;
                     end
                  end else if (key_hit) begin
                     res_status_in = STATUS_DUP;
                     res_slot_in   = k_ff;
                  end else begin
                     // occupied by another key: mark the collision and move on unless this was the last probe
                     slot_we         = 1'b1;
                     slot_wdata.coll = 1'b1;
                     if (last) begin
                        res_status_in = STATUS_FULL;
                     end else begin
                        n_in     = n_ff + 1'b1;
                        state_in = S_NEXT;
                     end
                  end
               end
               OP_REMOVE: begin
                  if (!walk_ff) begin
                     if (flood_q != 12'd0) begin
                        flood_we    = 1'b1;
                        flood_wdata = flood_q - 12'd1;
                     end
                     if (ent_v) begin
                        slot_we          = 1'b1;
                        slot_wdata.valid = 1'b0;
                        if (occ_ff != '0) begin
                           occ_in = occ_ff - 1'b1;
                        end
                        // end of a chain: clear marks walking backward
                        if (!ent_c) begin
                           walk_in  = 1'b1;
                           n_in     = '0;
                           state_in = S_NEXT;
                        end
                     end
                  end else if (ent_c) begin
                     slot_we         = 1'b1;
                     slot_wdata.coll = 1'b0;
                     if (!ent_v && !last) begin
                        n_in     = n_ff + 1'b1;
                        state_in = S_NEXT;
                     end
                  end
               end
               OP_READ: begin
                  if (ent_v) begin
                     res_found_in = 1'b1;
                     res_key_in   = slot_q.key;
                  end
               end
               default: ;
            endcase
         end
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // output register loads from the working result
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_flood_in   = rsp_flood_ff;
      rsp_flooded_in = rsp_flooded_ff;
      rsp_key_in     = rsp_key_ff;
      rsp_pop_in     = rsp_pop_ff;
      if (state_ff == S_OUT && out_free) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = res_status_ff;
         rsp_found_in   = res_found_ff;
         rsp_slot_in    = 11'(res_slot_ff);
         rsp_flood_in   = 11'(res_flood_ff);
         rsp_flooded_in = res_flooded_ff;
         rsp_key_in     = res_key_ff;
         rsp_pop_in     = 12'(occ_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         occ_ff       <= '0;
         closed_ff    <= 1'b0;
         walk_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         occ_ff       <= occ_in;
         closed_ff    <= closed_in;
         walk_ff      <= walk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      ip_ff          <= ip_in;
      port_ff        <= port_in;
      k_ff           <= k_in;
      f_ff           <= f_in;
      n_ff           <= n_in;
      h_ff           <= h_in;
      mul_ff         <= mul_in;
      res_status_ff  <= res_status_in;
      res_found_ff   <= res_found_in;
      res_slot_ff    <= res_slot_in;
      res_flood_ff   <= res_flood_in;
      res_flooded_ff <= res_flooded_in;
      res_key_ff     <= res_key_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_flood_ff   <= rsp_flood_in;
      rsp_flooded_ff <= rsp_flooded_in;
      rsp_key_ff     <= rsp_key_in;
      rsp_pop_ff     <= rsp_pop_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_slot_out    = rsp_slot_ff;
   assign rsp_flood_out   = rsp_flood_ff;
   assign rsp_flooded     = rsp_flooded_ff;
   assign rsp_stored_ip   = rsp_key_ff[47:16];
   assign rsp_stored_port = rsp_key_ff[15:0];
   assign rsp_population  = rsp_pop_ff;

`ifndef SYNTH
   // population never exceeds the table
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= (AW+1)'(TABLE_SIZE))
      else $error("population above table size");

   // once shut down the table stays shut and empty
   a_closed_sticky: assert property (@(posedge clock) disable iff (reset)
      closed_ff |=> closed_ff && occ_ff == '0)
      else $error("shut down table reopened or refilled");

   // a new result only appears from the output step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result without output step");
`endif

endmodule

@@ hw/rtl/cht_ram.sv @@
// cht_ram: generic simple dual port ram, one write and one registered read
// no dependencies
module cht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
